// ===== sv/smr_pkg.sv =====
// shared constants and types for the spiral order matrix reader
package smr_pkg;

   // payload and register widths
   localparam int VALUE_W     = 14;
   localparam int SIZE_W      = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   // register map: index taken from the word address bit
   localparam logic CSR_IDX_MATRIX_SIZE = 1'b0;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd2;
   localparam int MIN_SIDE = 2;

   // job queue and double-buffered store
   localparam int JOB_DEPTH = 2;
   localparam int JOB_PTR_W = 1;
   localparam int JOB_CNT_W = 2;
   localparam int NUM_BANKS = 2;

   // occupancy of the store banks, seen by the front end
   typedef struct packed {
      logic [JOB_CNT_W-1:0] queued;
      logic                 walking;
   } bank_occ_type;

endpackage

// ===== sv/smr_req_if.sv =====
// input channel carrying one matrix element per beat
interface smr_req_if;
   import smr_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] element_value;

   modport source (output valid, output element_value, input ready);
   modport sink   (input valid, input element_value, output ready);
endinterface

// ===== sv/smr_rsp_if.sv =====
// result channel carrying one spiral element per beat
interface smr_rsp_if;
   import smr_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] spiral_value;
   logic               last_of_run;

   modport source (output valid, output spiral_value, output last_of_run, input ready);
   modport sink   (input valid, input spiral_value, input last_of_run, output ready);
endinterface

// ===== sv/smr_front.sv =====
// front end: accepts elements, writes the load bank, queues finished matrices
module smr_front #(
   parameter int SIDE_W = 4,
   parameter int ADDR_W = 6,
   parameter int CNT_W  = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   smr_req_if.sink                  req_chan,
   input  logic [SIDE_W-1:0]        side,
   input  smr_pkg::bank_occ_type    occ,
   output logic                     wr_en,
   output logic [ADDR_W:0]          wr_addr,
   output logic [smr_pkg::VALUE_W-1:0] wr_data,
   output logic                     job_push,
   output logic [SIDE_W:0]          job_data
);
   import smr_pkg::*;

   localparam int TOT_W = 2 * SIDE_W;
   localparam int CMP_W = (CNT_W > TOT_W) ? CNT_W : TOT_W;

   logic [CNT_W-1:0]      load_cnt_ff, load_cnt_in;
   logic                  bank_ff, bank_in;
   logic [JOB_CNT_W:0]    busy_banks;
   logic                  accept;
   logic                  done;
   logic [CNT_W-1:0]      cnt_next;
   logic [TOT_W-1:0]      total;

   // a bank is free unless it is queued or being walked
   assign busy_banks = {1'b0, occ.queued} + {{JOB_CNT_W{1'b0}}, occ.walking};
   assign req_chan.ready = (busy_banks < (JOB_CNT_W+1)'(NUM_BANKS));
   assign accept = req_chan.valid && req_chan.ready;

   // matrix is complete once the count reaches side squared
   assign total    = TOT_W'(side) * TOT_W'(side);
   assign cnt_next = load_cnt_ff + 1'b1;
   assign done     = accept && (CMP_W'(cnt_next) >= CMP_W'(total));

   // store write, row-major into the current load bank
   assign wr_en   = accept;
   assign wr_addr = {bank_ff, load_cnt_ff[ADDR_W-1:0]};
   assign wr_data = req_chan.element_value;

   // hand the finished bank to the back end
   assign job_push = done;
   assign job_data = {bank_ff, side};

   always_comb begin
      load_cnt_in = load_cnt_ff;
      bank_in     = bank_ff;
      if (done) begin
         load_cnt_in = '0;
         bank_in     = ~bank_ff;
      end else if (accept) begin
         load_cnt_in = cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
         bank_ff     <= 1'b0;
      end else begin
         load_cnt_ff <= load_cnt_in;
         bank_ff     <= bank_in;
      end
   end
endmodule

// ===== sv/smr_job_fifo.sv =====
// two-entry queue of finished matrices between front and back
module smr_job_fifo #(
   parameter int WIDTH = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [WIDTH-1:0]              push_data,
   input  logic                          pop,
   output logic [WIDTH-1:0]              pop_data,
   output logic [smr_pkg::JOB_CNT_W-1:0] count
);
   import smr_pkg::*;

   logic [WIDTH-1:0]     entry_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0] count_ff, count_in;

   assign pop_data = entry_ff[rd_ptr_ff];
   assign count    = count_ff;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entries carry payload only
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ===== sv/smr_store.sv =====
// two-bank element store, one write port and one registered read port
module smr_store #(
   parameter int MEM_AW = 7
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [MEM_AW-1:0]           wr_addr,
   input  logic [smr_pkg::VALUE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [MEM_AW-1:0]           rd_addr,
   output logic [smr_pkg::VALUE_W-1:0] rd_data
);
   import smr_pkg::*;

   logic [VALUE_W-1:0] mem [2**MEM_AW];
   logic [VALUE_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while the output stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end
endmodule

// ===== sv/smr_back.sv =====
// back end: walks one bank in clockwise spiral order and drives the result beats
module smr_back #(
   parameter int SIDE_W = 4,
   parameter int POS_W  = 3,
   parameter int ADDR_W = 6,
   parameter int CNT_W  = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [smr_pkg::JOB_CNT_W-1:0] job_count,
   input  logic [SIDE_W:0]               job_data,
   output logic                          job_pop,
   output logic                          walking,
   output logic                          rd_en,
   output logic [ADDR_W:0]               rd_addr,
   input  logic [smr_pkg::VALUE_W-1:0]   rd_data,
   smr_rsp_if.source                     rsp_chan
);
   import smr_pkg::*;

   localparam int PROD_W = POS_W + SIDE_W;
   localparam int TOT_W  = 2 * SIDE_W;

   typedef enum logic {ST_IDLE, ST_WALK} state_type;
   typedef enum logic [1:0] {DIR_RIGHT, DIR_DOWN, DIR_LEFT, DIR_UP} dir_type;

   state_type         state_ff, state_in;
   dir_type           dir_ff, dir_in;
   logic              bank_ff, bank_in;
   logic [SIDE_W-1:0] side_ff, side_in;
   logic [POS_W-1:0]  row_ff, row_in;
   logic [POS_W-1:0]  col_ff, col_in;
   logic [POS_W-1:0]  top_ff, top_in;
   logic [POS_W-1:0]  bottom_ff, bottom_in;
   logic [POS_W-1:0]  left_ff, left_in;
   logic [POS_W-1:0]  right_ff, right_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_last_ff, out_last_in;

   logic              issue;
   logic [SIDE_W-1:0] job_side;
   logic [PROD_W-1:0] row_base;
   logic [ADDR_W-1:0] cell_idx;

   // one read per free output slot
   assign issue   = (state_ff == ST_WALK) && (!out_valid_ff || rsp_chan.ready);
   assign job_pop = (state_ff == ST_IDLE) && (job_count != '0);
   assign walking = (state_ff == ST_WALK);
   assign job_side = job_data[SIDE_W-1:0];

   // row-major address of the current cell
   assign row_base = PROD_W'(row_ff) * PROD_W'(side_ff);
   assign cell_idx = ADDR_W'(row_base + PROD_W'(col_ff));
   assign rd_en    = issue;
   assign rd_addr  = {bank_ff, cell_idx};

   // result beat: data straight from the store's read register
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.spiral_value = rd_data;
   assign rsp_chan.last_of_run  = out_last_ff;

   // walker and sequencer next state
   always_comb begin
      state_in  = state_ff;
      dir_in    = dir_ff;
      bank_in   = bank_ff;
      side_in   = side_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      top_in    = top_ff;
      bottom_in = bottom_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      remain_in = remain_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (job_pop) begin
               bank_in   = job_data[SIDE_W];
               side_in   = job_side;
               row_in    = '0;
               col_in    = '0;
               top_in    = '0;
               left_in   = '0;
               bottom_in = POS_W'(job_side - 1'b1);
               right_in  = POS_W'(job_side - 1'b1);
               dir_in    = DIR_RIGHT;
               remain_in = CNT_W'(TOT_W'(job_side) * TOT_W'(job_side));
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            if (issue) begin
               remain_in = remain_ff - 1'b1;
               if (remain_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
               // step along the ring, turning and shrinking at each corner
               unique case (dir_ff)
                  DIR_RIGHT: begin
                     if (col_ff < right_ff) begin
                        col_in = col_ff + 1'b1;
                     end else begin
                        top_in = top_ff + 1'b1;
                        dir_in = DIR_DOWN;
                        row_in = row_ff + 1'b1;
                     end
                  end
                  DIR_DOWN: begin
                     if (row_ff < bottom_ff) begin
                        row_in = row_ff + 1'b1;
                     end else begin
                        right_in = right_ff - 1'b1;
                        dir_in   = DIR_LEFT;
                        col_in   = col_ff - 1'b1;
                     end
                  end
                  DIR_LEFT: begin
                     if (col_ff > left_ff) begin
                        col_in = col_ff - 1'b1;
                     end else begin
                        bottom_in = bottom_ff - 1'b1;
                        dir_in    = DIR_UP;
                        row_in    = row_ff - 1'b1;
                     end
                  end
                  DIR_UP: begin
                     if (row_ff > top_ff) begin
                        row_in = row_ff - 1'b1;
                     end else begin
                        left_in = left_ff + 1'b1;
                        dir_in  = DIR_RIGHT;
                        col_in  = col_ff + 1'b1;
                     end
                  end
               endcase
            end
         end
      endcase
   end

   // output slot: filled on a read, emptied when the beat is taken
   always_comb begin
      out_valid_in = out_valid_ff;
      out_last_in  = out_last_ff;
      if (issue) begin
         out_valid_in = 1'b1;
         out_last_in  = (remain_ff == CNT_W'(1));
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      dir_ff      <= dir_in;
      bank_ff     <= bank_in;
      side_ff     <= side_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      top_ff      <= top_in;
      bottom_ff   <= bottom_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      remain_ff   <= remain_in;
      out_last_ff <= out_last_in;
   end
endmodule

// ===== sv/spiral_order_matrix_reader.sv =====
// top level: takes one element per beat, returns side*side beats in spiral order per matrix
// input: one element per cycle while a store bank is free; two banks let a load overlap a walk
// throughput: one spiral beat per cycle while the consumer takes them, set by the read port
// reset: clears load count, load bank pointer, job queue and output valid; size reads back 2
// reset: the element store itself is not cleared and needs no clearing pass
module spiral_order_matrix_reader #(
   parameter int MAX_SIDE = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   smr_req_if.sink                        req_chan,
   smr_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [smr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [smr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [smr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import smr_pkg::*;

   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int POS_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int CELLS  = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);

   logic [SIZE_W-1:0]    matrix_size_ff, matrix_size_in;
   logic                 csr_idx;
   logic                 csr_wr;
   logic [SIDE_W-1:0]    side;
   bank_occ_type         occ;
   logic                 wr_en;
   logic [ADDR_W:0]      wr_addr;
   logic [VALUE_W-1:0]   wr_data;
   logic                 rd_en;
   logic [ADDR_W:0]      rd_addr;
   logic [VALUE_W-1:0]   rd_data;
   logic                 job_push;
   logic [SIDE_W:0]      job_push_data;
   logic                 job_pop;
   logic [SIDE_W:0]      job_pop_data;
   logic [JOB_CNT_W-1:0] job_count;
   logic                 walking;

   // register port: one register, written in the access phase
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1];
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_idx == CSR_IDX_MATRIX_SIZE);
   assign csr_prdata = (csr_idx == CSR_IDX_MATRIX_SIZE) ? CSR_DATA_W'(matrix_size_ff) : '0;
   assign matrix_size_in = csr_wr ? csr_pwdata[SIZE_W-1:0] : matrix_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_size_ff <= SIZE_RESET;
      end else begin
         matrix_size_ff <= matrix_size_in;
      end
   end

   // side in force, clamped to the supported range
   always_comb begin
      if (32'(matrix_size_ff) < MIN_SIDE) begin
         side = SIDE_W'(MIN_SIDE);
      end else if (32'(matrix_size_ff) > MAX_SIDE) begin
         side = SIDE_W'(MAX_SIDE);
      end else begin
         side = SIDE_W'(matrix_size_ff);
      end
   end

   assign occ.queued  = job_count;
   assign occ.walking = walking;

   smr_front #(
      .SIDE_W (SIDE_W),
      .ADDR_W (ADDR_W),
      .CNT_W  (CNT_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .side     (side),
      .occ      (occ),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .job_push (job_push),
      .job_data (job_push_data)
   );

   smr_job_fifo #(
      .WIDTH (SIDE_W + 1)
   ) u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_push_data),
      .pop       (job_pop),
      .pop_data  (job_pop_data),
      .count     (job_count)
   );

   smr_store #(
      .MEM_AW (ADDR_W + 1)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   smr_back #(
      .SIDE_W (SIDE_W),
      .POS_W  (POS_W),
      .ADDR_W (ADDR_W),
      .CNT_W  (CNT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_count (job_count),
      .job_data  (job_pop_data),
      .job_pop   (job_pop),
      .walking   (walking),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_chan  (rsp_chan)
   );
endmodule

// ===== sv/smr_checker.sv =====
// port-level checker for the spiral order matrix reader and its bind
module smr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [smr_pkg::VALUE_W-1:0] rsp_spiral_value,
   input logic                        rsp_last_of_run,
   input logic                        csr_pready
);
   import smr_pkg::*;

   logic [6:0] beat_cnt_ff, beat_cnt_in;
   logic [6:0] run_len;
   logic       taken;

   // beats taken since the last end of run
   assign taken   = rsp_valid && rsp_ready;
   assign run_len = beat_cnt_ff + 1'b1;

   always_comb begin
      beat_cnt_in = beat_cnt_ff;
      if (taken) begin
         beat_cnt_in = rsp_last_of_run ? '0 : run_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_cnt_ff <= '0;
      end else begin
         beat_cnt_ff <= beat_cnt_in;
      end
   end

   // a stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_spiral_value) &&
      $stable(rsp_last_of_run))
      else $error("result beat changed while stalled");

   // no result beat right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a run always holds a square number of beats
   a_run_square: assert property (@(posedge clock) disable iff (reset)
      taken && rsp_last_of_run |->
      (run_len == 7'd4 || run_len == 7'd9 || run_len == 7'd16 || run_len == 7'd25 ||
       run_len == 7'd36 || run_len == 7'd49 || run_len == 7'd64))
      else $error("spiral run length is not a square");

   // a run never runs past a full matrix
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      taken && !rsp_last_of_run |-> beat_cnt_ff < 7'd63)
      else $error("spiral run too long");

   // register port never inserts wait states
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready low");
endmodule

bind spiral_order_matrix_reader smr_checker u_smr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_spiral_value (rsp_chan.spiral_value),
   .rsp_last_of_run  (rsp_chan.last_of_run),
   .csr_pready       (csr_pready)
);
